// ===== rtl/cmrf_pkg.sv =====
// ----------------------------------------------------------------------------
// CAN receive FIFO package
// Shared constants, record layout and control types for the receive FIFO.
// ----------------------------------------------------------------------------
`default_nettype none

package cmrf_pkg;

   localparam int DEPTH_DEFAULT = 32;
   localparam int ID_W          = 29;
   localparam int LEN_W         = 4;
   localparam int BYTES_W       = 64;
   localparam int TIME_W        = 32;
   localparam int FILL_W        = 6;
   localparam int MAX_BYTES     = 8;

   localparam logic FUNC_PUSH = 1'b0;
   localparam logic FUNC_POP  = 1'b1;

   typedef struct packed {
      logic [ID_W-1:0]    id;
      logic [LEN_W-1:0]   len;
      logic [BYTES_W-1:0] bytes;
      logic [TIME_W-1:0]  stamp;
   } record_type;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_EXEC = 3'b010,
      ST_RESP = 3'b100
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic exec;
      logic respond;
   } cmd_type;

endpackage

`default_nettype wire

// ===== rtl/can_message_rx_fifo_top.sv =====
// ----------------------------------------------------------------------------
// CAN message receive FIFO
// Circular buffer of CAN records with push and pop commands.
// ----------------------------------------------------------------------------
//  Channel   Handshake           Ports
//  request   start, busy         req_func, req_msg_id, req_msg_len,
//                                req_msg_bytes, req_msg_time
//  response  rsp_valid strobe    rsp_ok, rsp_out_*, rsp_fill_level,
//                                rsp_empty_flag, rsp_full_flag
//
// Every command passes through capture, execute and response. The response
// beat follows the execute state, and a new command is taken in the cycle
// after it. The registered read port of the record memory sets the execute
// step. Reset clears the pointers and the fill count at once; the memory
// needs no clearing pass. The receiver cannot stall the response.
// ----------------------------------------------------------------------------
`default_nettype none

module can_message_rx_fifo_top
   import cmrf_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   output logic                     busy,
   input  wire logic                req_func,
   input  wire logic [ID_W-1:0]     req_msg_id,
   input  wire logic [LEN_W-1:0]    req_msg_len,
   input  wire logic [BYTES_W-1:0]  req_msg_bytes,
   input  wire logic [TIME_W-1:0]   req_msg_time,
   output logic                     rsp_valid,
   output logic                     rsp_ok,
   output logic [ID_W-1:0]          rsp_out_id,
   output logic [LEN_W-1:0]         rsp_out_len,
   output logic [BYTES_W-1:0]       rsp_out_bytes,
   output logic [TIME_W-1:0]        rsp_out_time,
   output logic [FILL_W-1:0]        rsp_fill_level,
   output logic                     rsp_empty_flag,
   output logic                     rsp_full_flag
);

   cmd_type cmd;

   cmrf_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd)
   );

   cmrf_dp #(
      .DEPTH (DEPTH)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .req_func       (req_func),
      .req_msg_id     (req_msg_id),
      .req_msg_len    (req_msg_len),
      .req_msg_bytes  (req_msg_bytes),
      .req_msg_time   (req_msg_time),
      .rsp_valid      (rsp_valid),
      .rsp_ok         (rsp_ok),
      .rsp_out_id     (rsp_out_id),
      .rsp_out_len    (rsp_out_len),
      .rsp_out_bytes  (rsp_out_bytes),
      .rsp_out_time   (rsp_out_time),
      .rsp_fill_level (rsp_fill_level),
      .rsp_empty_flag (rsp_empty_flag),
      .rsp_full_flag  (rsp_full_flag)
   );

endmodule

`default_nettype wire

// ===== rtl/cmrf_ctrl.sv =====
// ----------------------------------------------------------------------------
// CAN receive FIFO controller
// Sequences one command through capture, execute and response.
// ----------------------------------------------------------------------------
`default_nettype none

module cmrf_ctrl
   import cmrf_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   output cmd_type      cmd
);

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: state_in = ST_RESP;
         ST_RESP: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy        = (state_ff != ST_IDLE);
   assign cmd.load    = start && (state_ff == ST_IDLE);
   assign cmd.exec    = (state_ff == ST_EXEC);
   assign cmd.respond = (state_ff == ST_RESP);

endmodule

`default_nettype wire

// ===== rtl/cmrf_dp.sv =====
// ----------------------------------------------------------------------------
// CAN receive FIFO datapath
// Record storage, pointers, fill count and the response registers.
// ----------------------------------------------------------------------------
`default_nettype none

module cmrf_dp
   import cmrf_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire cmd_type             cmd,
   input  wire logic                req_func,
   input  wire logic [ID_W-1:0]     req_msg_id,
   input  wire logic [LEN_W-1:0]    req_msg_len,
   input  wire logic [BYTES_W-1:0]  req_msg_bytes,
   input  wire logic [TIME_W-1:0]   req_msg_time,
   output logic                     rsp_valid,
   output logic                     rsp_ok,
   output logic [ID_W-1:0]          rsp_out_id,
   output logic [LEN_W-1:0]         rsp_out_len,
   output logic [BYTES_W-1:0]       rsp_out_bytes,
   output logic [TIME_W-1:0]        rsp_out_time,
   output logic [FILL_W-1:0]        rsp_fill_level,
   output logic                     rsp_empty_flag,
   output logic                     rsp_full_flag
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int EXT_W = (CNT_W > FILL_W) ? CNT_W : FILL_W;
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   record_type          mem [DEPTH];
   record_type          rec_ff, rec_in;
   record_type          rd_data_ff;
   logic                func_ff;
   logic                ok_ff, ok_in;
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [LEN_W-1:0]    len_clamped;
   logic [EXT_W-1:0]    count_ext;
   logic                is_full;
   logic                is_empty;
   logic                do_push;
   logic                do_pop;

   // The length code is clamped and bytes beyond it cleared as the beat is taken.
   always_comb begin
      len_clamped = (req_msg_len > LEN_W'(MAX_BYTES)) ? LEN_W'(MAX_BYTES) : req_msg_len;
      rec_in.id    = req_msg_id;
      rec_in.len   = len_clamped;
      rec_in.stamp = req_msg_time;
      for (int i = 0; i < MAX_BYTES; i++) begin
         rec_in.bytes[i*8 +: 8] = (LEN_W'(i) < len_clamped) ? req_msg_bytes[i*8 +: 8] : 8'h00;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rec_ff  <= rec_in;
         func_ff <= req_func;
      end
   end

   assign is_full  = (count_ff == CNT_FULL);
   assign is_empty = (count_ff == '0);
   assign do_push  = cmd.exec && (func_ff == FUNC_PUSH) && !is_full;
   assign do_pop   = cmd.exec && (func_ff == FUNC_POP) && !is_empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      ok_in     = ok_ff;
      if (cmd.exec) begin
         ok_in = do_push || do_pop;
      end
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
         count_in  = count_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
         count_in  = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      ok_ff <= ok_in;
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= rec_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (do_pop) begin
         rd_data_ff <= mem[rd_ptr_ff];
      end
   end

   // The count has already moved when the response beat goes out.
   assign count_ext = EXT_W'(count_ff);

   always_comb begin
      rsp_valid      = cmd.respond;
      rsp_ok         = ok_ff;
      rsp_out_id     = '0;
      rsp_out_len    = '0;
      rsp_out_bytes  = '0;
      rsp_out_time   = '0;
      if (ok_ff && (func_ff == FUNC_POP)) begin
         rsp_out_id    = rd_data_ff.id;
         rsp_out_len   = rd_data_ff.len;
         rsp_out_bytes = rd_data_ff.bytes;
         rsp_out_time  = rd_data_ff.stamp;
      end
      rsp_fill_level = count_ext[FILL_W-1:0];
      rsp_empty_flag = is_empty;
      rsp_full_flag  = is_full;
   end

endmodule

`default_nettype wire
